// ===== rtl/bksl_pkg.sv =====
// Package for the B-spline knot span locator.
// Holds field widths, command and register codes, shared structs and the
// sequencer state type. Depends on nothing.
package bksl_pkg;

  localparam int IDX_W         = 8;
  localparam int KNOT_W        = 32;
  localparam int TOL_W         = 31;
  localparam int ORDER_W       = 5;
  localparam int COUNT_W       = 8;
  localparam int MAX_KNOTS_DEF = 256;

  localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(4);
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(4);

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_LOCATE = 2'd1,
    CMD_FUZZY  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic {
    REG_SPLINE_ORDER = 1'b0,
    REG_COEF_COUNT   = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [ORDER_W-1:0] spline_order;
    logic [COUNT_W-1:0] coef_count;
  } cfg_t;

  typedef struct packed {
    logic lt;    // a < b
    logic eq;    // a == b
    logic near;  // a - b < tolerance
  } cmp_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK_LOW,
    ST_CHK_HIGH,
    ST_BND_HI,
    ST_BND_LO,
    ST_STEP_UP,
    ST_STEP_DN,
    ST_BS_LOW,
    ST_BS_HIGH,
    ST_FINISH,
    ST_SNAP_LO,
    ST_SNAP_HI,
    ST_SKIP
  } state_t;

endpackage

// ===== rtl/bksl_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module bksl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/bksl_cmp.sv =====
// Shared compare unit: one 33-bit subtractor gives less-than, equality and
// the tolerance test. Depends on bksl_pkg.
module bksl_cmp import bksl_pkg::*; (
  input  logic signed [KNOT_W-1:0] a,
  input  logic signed [KNOT_W-1:0] b,
  input  logic        [TOL_W-1:0]  tol,
  output cmp_res_t                 res
);

  logic signed [KNOT_W:0] diff;

  assign diff     = {a[KNOT_W-1], a} - {b[KNOT_W-1], b};
  assign res.lt   = diff[KNOT_W];
  assign res.eq   = (diff == '0);
  assign res.near = (diff < $signed({2'b00, tol}));

endmodule

// ===== rtl/bksl_seq.sv =====
// Span search sequencer: issues one knot read per cycle, drives the shared
// compare unit and holds the search registers. Depends on bksl_pkg, bksl_cmp.
module bksl_seq import bksl_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  cfg_t                     cfg,
  input  logic                     start,
  input  cmd_t                     cmd,
  input  logic signed [KNOT_W-1:0] query_point,
  input  logic        [TOL_W-1:0]  tolerance,
  input  logic signed [KNOT_W-1:0] knot_data,
  output logic        [IDX_W-1:0]  rd_index,
  output logic                     busy,
  output logic                     done,
  output logic        [IDX_W-1:0]  span_index,
  output logic signed [KNOT_W-1:0] snapped_point
);

  function automatic logic [IDX_W-1:0] mid(input logic [IDX_W-1:0] x,
                                           input logic [IDX_W-1:0] y);
    logic [IDX_W:0] sum;
    sum = {1'b0, x} + {1'b0, y};
    return sum[IDX_W:1];
  endfunction

  state_t state, state_next;
  logic [IDX_W-1:0] s, s_next, lo, lo_next, hi, hi_next;
  logic [IDX_W-1:0] kmin, kmin_next, kmax, kmax_next, cached, cached_next;
  logic signed [KNOT_W-1:0] t, t_next, ks, ks_next;
  logic [TOL_W-1:0] tol, tol_next;
  logic fuzzy, fuzzy_next, tge0, tge0_next, tlt1, tlt1_next, tltks, tltks_next;

  logic [IDX_W-1:0] lo_c, hi_raw, hi_c, s0, bs_mid, s_p1, s_p2, s_m1;
  logic [IDX_W-1:0] kmin_bs, kmax_bs, bs_new;
  logic [IDX_W:0]   hi_p1, s_p1_w;
  logic             emit;
  logic [IDX_W-1:0] emit_span;
  logic signed [KNOT_W-1:0] emit_point, a_op, b_op;
  logic             a_swap, a_ks;
  cmp_res_t         cr;

  bksl_cmp u_cmp (
    .a   (a_op),
    .b   (b_op),
    .tol (tol),
    .res (cr)
  );

  assign a_op = a_swap ? knot_data : (a_ks ? ks : t);
  assign b_op = a_swap ? t : knot_data;

  // Span bounds from the live configuration; the cached span is pulled
  // back to the lower bound when it falls outside them.
  assign lo_c   = (cfg.spline_order == '0) ? '0
                : IDX_W'(cfg.spline_order) - IDX_W'(1);
  assign hi_raw = (cfg.coef_count == '0) ? '0 : IDX_W'(cfg.coef_count) - IDX_W'(1);
  assign hi_c   = (hi_raw < lo_c) ? lo_c : hi_raw;
  assign s0     = (cached < lo_c || cached > hi_c) ? lo_c : cached;

  assign bs_mid  = mid(lo, hi);
  assign s_p1    = s + IDX_W'(1);
  assign s_p2    = s + IDX_W'(2);
  assign s_m1    = s - IDX_W'(1);
  assign hi_p1   = {1'b0, hi} + (IDX_W+1)'(1);
  assign s_p1_w  = {1'b0, s} + (IDX_W+1)'(1);
  assign kmin_bs = tltks ? kmin : s;
  assign kmax_bs = tltks ? s : kmax;
  assign bs_new  = mid(kmin_bs, kmax_bs);

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      cached <= '0;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      cached <= cached_next;
      done   <= emit;
    end
    s     <= s_next;
    lo    <= lo_next;
    hi    <= hi_next;
    kmin  <= kmin_next;
    kmax  <= kmax_next;
    t     <= t_next;
    ks    <= ks_next;
    tol   <= tol_next;
    fuzzy <= fuzzy_next;
    tge0  <= tge0_next;
    tlt1  <= tlt1_next;
    tltks <= tltks_next;
    if (emit) begin
      span_index    <= emit_span;
      snapped_point <= emit_point;
    end
  end

  always_comb begin
    state_next  = state;
    s_next      = s;
    lo_next     = lo;
    hi_next     = hi;
    kmin_next   = kmin;
    kmax_next   = kmax;
    t_next      = t;
    ks_next     = ks;
    tol_next    = tol;
    fuzzy_next  = fuzzy;
    tge0_next   = tge0;
    tlt1_next   = tlt1;
    tltks_next  = tltks;
    cached_next = cached;
    rd_index    = s;
    a_swap      = 1'b0;
    a_ks        = 1'b0;
    emit        = 1'b0;
    emit_span   = s;
    emit_point  = t;

    unique case (state)
      ST_IDLE: begin
        rd_index = s0;
        if (start && (cmd == CMD_LOCATE || cmd == CMD_FUZZY)) begin
          lo_next    = lo_c;
          hi_next    = hi_c;
          s_next     = s0;
          t_next     = query_point;
          tol_next   = tolerance;
          fuzzy_next = (cmd == CMD_FUZZY);
          state_next = ST_CHK_LOW;
        end
      end
      ST_CHK_LOW: begin
        tge0_next  = !cr.lt;
        rd_index   = s_p1;
        state_next = ST_CHK_HIGH;
      end
      ST_CHK_HIGH: begin
        tlt1_next = cr.lt;
        if (tge0 && cr.lt) begin
          state_next = ST_FINISH;
        end else begin
          rd_index   = hi;
          state_next = ST_BND_HI;
        end
      end
      ST_BND_HI: begin
        if (!cr.lt) begin
          s_next     = hi;
          state_next = ST_FINISH;
        end else begin
          rd_index   = lo;
          state_next = ST_BND_LO;
        end
      end
      ST_BND_LO: begin
        if (cr.lt || cr.eq) begin
          s_next     = lo;
          state_next = ST_FINISH;
        end else if (s < hi) begin
          rd_index   = s_p2;
          state_next = ST_STEP_UP;
        end else if (s > lo) begin
          rd_index   = s_m1;
          state_next = ST_STEP_DN;
        end else begin
          rd_index   = bs_mid;
          kmin_next  = lo;
          kmax_next  = hi;
          s_next     = bs_mid;
          state_next = ST_BS_LOW;
        end
      end
      ST_STEP_UP: begin
        if (!tlt1 && cr.lt) begin
          s_next     = s_p1;
          state_next = ST_FINISH;
        end else if (s > lo) begin
          rd_index   = s_m1;
          state_next = ST_STEP_DN;
        end else begin
          rd_index   = bs_mid;
          kmin_next  = lo;
          kmax_next  = hi;
          s_next     = bs_mid;
          state_next = ST_BS_LOW;
        end
      end
      ST_STEP_DN: begin
        if (!cr.lt && !tge0) begin
          s_next     = s_m1;
          state_next = ST_FINISH;
        end else begin
          rd_index   = bs_mid;
          kmin_next  = lo;
          kmax_next  = hi;
          s_next     = bs_mid;
          state_next = ST_BS_LOW;
        end
      end
      ST_BS_LOW: begin
        tltks_next = cr.lt;
        rd_index   = s_p1;
        state_next = ST_BS_HIGH;
      end
      ST_BS_HIGH: begin
        // Keep halving while t lies outside the probed span and the
        // bounds are not yet adjacent.
        if ((tltks || !cr.lt) && (kmax - kmin) > IDX_W'(1)) begin
          kmin_next  = kmin_bs;
          kmax_next  = kmax_bs;
          s_next     = bs_new;
          rd_index   = bs_new;
          state_next = ST_BS_LOW;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (fuzzy) begin
          state_next = ST_SNAP_LO;
        end else begin
          emit        = 1'b1;
          cached_next = s;
          state_next  = ST_IDLE;
        end
      end
      ST_SNAP_LO: begin
        if (cr.near) begin
          emit        = 1'b1;
          emit_point  = knot_data;
          cached_next = s;
          state_next  = ST_IDLE;
        end else begin
          rd_index   = s_p1;
          state_next = ST_SNAP_HI;
        end
      end
      ST_SNAP_HI: begin
        a_swap = 1'b1;
        if (cr.near) begin
          t_next  = knot_data;
          ks_next = knot_data;
          if (s_p1_w < hi_p1) begin
            s_next     = s_p1;
            rd_index   = s_p2;
            state_next = ST_SKIP;
          end else begin
            emit        = 1'b1;
            emit_span   = hi;
            emit_point  = knot_data;
            cached_next = hi;
            state_next  = ST_IDLE;
          end
        end else begin
          emit        = 1'b1;
          cached_next = s;
          state_next  = ST_IDLE;
        end
      end
      ST_SKIP: begin
        // Step over repeated knots after an upward snap.
        a_ks = 1'b1;
        if (cr.eq && s_p1_w < hi_p1) begin
          s_next   = s_p1;
          rd_index = s_p2;
        end else if (cr.eq) begin
          emit        = 1'b1;
          emit_span   = hi;
          cached_next = hi;
          state_next  = ST_IDLE;
        end else begin
          emit        = 1'b1;
          cached_next = s;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/bspline_knot_span_locator_top.sv =====
// Top level of the B-spline knot span locator: register port, knot RAM and
// the span search sequencer. Depends on bksl_pkg, bksl_ram, bksl_seq.
//
//   Channel   Handshake              Ports
//   --------  ---------------------  -------------------------------------------
//   item in   start && !busy         cmd, knot_index, knot_value, query_point,
//                                    tolerance
//   result    done (one-cycle pulse) span_index, snapped_point
//   config    psel&penable&pwrite    paddr, pwdata, prdata, pready
//
// A write-knot item or an unused command is taken at once and never raises
// busy. A locate item keeps busy high for a cached-span check, then, on a
// miss, the boundary and neighbor checks, then a binary search that reads
// two knots per probe (at most 9 probes for 255 spans). A fuzzy locate adds
// the snap checks, plus one read per repeated knot skipped. Search time is
// set by the single read port of the knot RAM: one knot is read and compared
// per cycle. The result pulse is high in the first cycle with busy low; the
// receiver cannot stall it. Reset clears the sequencer, the cached span and
// restores the registers to order 4 and count 4; the knot RAM is not cleared.
module bspline_knot_span_locator_top import bksl_pkg::*; #(
  parameter int MAX_KNOTS = MAX_KNOTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               cmd,
  input  logic [IDX_W-1:0]         knot_index,
  input  logic signed [KNOT_W-1:0] knot_value,
  input  logic signed [KNOT_W-1:0] query_point,
  input  logic [TOL_W-1:0]         tolerance,
  output logic                     done,
  output logic [IDX_W-1:0]         span_index,
  output logic signed [KNOT_W-1:0] snapped_point,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam int AW = $clog2(MAX_KNOTS);
  localparam int XW = AW + IDX_W;

  logic [ORDER_W-1:0] spline_order;
  logic [COUNT_W-1:0] coef_count;
  cfg_t               cfg;
  cmd_t               cmd_code;
  reg_idx_t           reg_sel;
  logic               cfg_wr;

  // Register port. Registers sit at byte addresses 0 and 4; the word
  // select is the only address bit decoded.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      spline_order <= ORDER_RESET;
      coef_count   <= COUNT_RESET;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_SPLINE_ORDER: spline_order <= pwdata[ORDER_W-1:0];
        REG_COEF_COUNT:   coef_count   <= pwdata[COUNT_W-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SPLINE_ORDER: prdata = {{(32-ORDER_W){1'b0}}, spline_order};
      REG_COEF_COUNT:   prdata = {{(32-COUNT_W){1'b0}}, coef_count};
      default:          prdata = '0;
    endcase
  end

  assign cfg.spline_order = spline_order;
  assign cfg.coef_count   = coef_count;
  assign cmd_code         = cmd_t'(cmd);

  // Knot store. Indices at or beyond the store depth are dropped on write
  // and read back as zero.
  logic [XW-1:0]     wr_ext, rd_ext;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic              wr_en, rd_oob;
  logic [IDX_W-1:0]  rd_index;
  logic [KNOT_W-1:0] ram_rdata;
  logic signed [KNOT_W-1:0] knot_data;

  assign wr_ext  = XW'(knot_index);
  assign wr_addr = wr_ext[AW-1:0];
  assign wr_en   = start && !busy && (cmd_code == CMD_WRITE) && (wr_ext < XW'(MAX_KNOTS));
  assign rd_ext  = XW'(rd_index);
  assign rd_addr = rd_ext[AW-1:0];

  always_ff @(posedge clk) begin
    rd_oob <= (rd_ext >= XW'(MAX_KNOTS));
  end

  bksl_ram #(
    .WIDTH (KNOT_W),
    .DEPTH (MAX_KNOTS)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (knot_value),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign knot_data = rd_oob ? '0 : $signed(ram_rdata);

  bksl_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .start         (start),
    .cmd           (cmd_code),
    .query_point   (query_point),
    .tolerance     (tolerance),
    .knot_data     (knot_data),
    .rd_index      (rd_index),
    .busy          (busy),
    .done          (done),
    .span_index    (span_index),
    .snapped_point (snapped_point)
  );

  // A locate item raises busy in the cycle after it is taken.
  a_locate_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd_code == CMD_LOCATE || cmd_code == CMD_FUZZY)) |=> busy)
    else $error("locate item did not raise busy");

  // Knot writes and unused commands finish at once and give no result.
  a_write_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd_code == CMD_WRITE || cmd_code == CMD_NONE))
      |=> (!busy && !done))
    else $error("write or unused item raised busy or a result");

  // A result only follows a search.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a preceding search");

endmodule
